>>> design/irpd_pkg.sv
package irpd_pkg;

   localparam int unsigned IntervalWidth = 16;
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned IndexWidth    = 4;
   localparam int unsigned CountWidth    = 8;
   localparam int unsigned ByteNoWidth   = CountWidth - 3;
   localparam int unsigned CsrAddrWidth  = 2;

   localparam int unsigned MaxBytes = 16;

   localparam logic [CsrAddrWidth-1:0] REG_LEADER_MAX = 2'd0;
   localparam logic [CsrAddrWidth-1:0] REG_LEADER_MIN = 2'd1;
   localparam logic [CsrAddrWidth-1:0] REG_BIT_SPLIT  = 2'd2;
   localparam logic [CsrAddrWidth-1:0] REG_BIT_MIN    = 2'd3;

   localparam logic [IntervalWidth-1:0] LEADER_MAX_RST = 16'd2000;
   localparam logic [IntervalWidth-1:0] LEADER_MIN_RST = 16'd800;
   localparam logic [IntervalWidth-1:0] BIT_SPLIT_RST  = 16'd180;
   localparam logic [IntervalWidth-1:0] BIT_MIN_RST    = 16'd60;

   typedef struct packed {
      logic [IntervalWidth-1:0] leader_max;
      logic [IntervalWidth-1:0] leader_min;
      logic [IntervalWidth-1:0] bit_split;
      logic [IntervalWidth-1:0] bit_min;
   } cfg_type;

   typedef struct packed {
      logic                  receiving;
      logic [CountWidth-1:0] bit_count;
      logic [ByteWidth-1:0]  shift_byte;
   } rx_state_type;

   typedef struct packed {
      logic                  emit;
      logic [ByteWidth-1:0]  rx_byte;
      logic [IndexWidth-1:0] byte_index;
   } rx_result_type;

endpackage

>>> design/irpd_step.sv
module irpd_step import irpd_pkg::*; (
   input  cfg_type                  cfg,
   input  rx_state_type             state,
   input  logic [IntervalWidth-1:0] edge_interval,
   output rx_state_type             state_next,
   output rx_result_type            result
);

   logic                   is_leader;
   logic                   is_zero;
   logic                   is_one;
   logic [ByteWidth-1:0]   sum_byte;
   logic [CountWidth-1:0]  cnt_inc;
   logic [CountWidth-1:0]  cnt_dec;
   logic [ByteNoWidth-1:0] byte_no;
   logic [ByteNoWidth:0]   byte_total;

   assign is_leader = (edge_interval > cfg.leader_min) && (edge_interval < cfg.leader_max);
   assign is_zero   = (edge_interval > cfg.bit_min) && (edge_interval < cfg.bit_split);
   assign is_one    = (edge_interval > cfg.bit_split) && (edge_interval < cfg.leader_min);

   assign sum_byte   = state.shift_byte + {{(ByteWidth-1){1'b0}}, (!is_zero && is_one)};
   assign cnt_inc    = state.bit_count + CountWidth'(1);
   assign cnt_dec    = cnt_inc - CountWidth'(1);
   assign byte_no    = cnt_dec[CountWidth-1:3];
   assign byte_total = {1'b0, byte_no} + (ByteNoWidth+1)'(1);

   always_comb begin
      state_next        = state;
      result.emit       = 1'b0;
      result.rx_byte    = sum_byte;
      result.byte_index = byte_no[IndexWidth-1:0];
      priority if (!state.receiving) begin
         state_next.receiving  = is_leader;
         state_next.bit_count  = '0;
         state_next.shift_byte = '0;
      end else if (!is_zero && !is_one) begin
         state_next.receiving = 1'b0;
      end else if (cnt_inc[2:0] != 3'd0) begin
         state_next.bit_count  = cnt_inc;
         state_next.shift_byte = {sum_byte[ByteWidth-2:0], 1'b0};
      end else begin
         state_next.bit_count  = cnt_inc;
         state_next.shift_byte = '0;
         result.emit           = 1'b1;
         if (byte_total >= (ByteNoWidth+1)'(MaxBytes)) begin
            state_next.receiving = 1'b0;
         end
      end
   end

endmodule

>>> design/ir_pulse_distance_receiver.sv
// Pulse-distance IR receiver. Each req_ transaction is one falling edge of the
// IR line, carrying the timer ticks since the previous edge. An idle edge whose
// interval lies strictly between leader_min and leader_max opens a frame; then
// each interval is a 0 bit (bit_min..bit_split) or a 1 bit (bit_split..leader_min),
// all bounds exclusive, and anything else drops the frame silently. Bits are
// packed MSB first and every full byte leaves on rsp_ with its index in the
// frame (mod 16); the frame closes after MaxBytes bytes. One edge is accepted
// every clock cycle unless a stalled rsp_ holds up the pipeline: an input
// register, one pass of compare-and-shift logic and the result register, from which
// a byte leaves on rsp_. Write the csr_ registers (0 leader_max, 1 leader_min,
// 2 bit_split, 3 bit_min) only while idle.
module ir_pulse_distance_receiver import irpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,  // [15:0] edge_interval
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,  // [7:0] rx_byte, [11:8] byte_index
   input  logic                     csr_we,
   input  logic [CsrAddrWidth-1:0]  csr_addr,
   input  logic [IntervalWidth-1:0] csr_wdata
);

   cfg_type                  cfg_ff;
   logic                     in_valid_ff;
   logic [IntervalWidth-1:0] in_interval_ff;
   rx_state_type             state_ff;
   rx_state_type             state_in;
   rx_result_type            result_in;
   logic                     out_valid_ff;
   logic [ByteWidth-1:0]     out_byte_ff;
   logic [IndexWidth-1:0]    out_index_ff;
   logic                     advance;
   logic                     step_fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_max <= LEADER_MAX_RST;
         cfg_ff.leader_min <= LEADER_MIN_RST;
         cfg_ff.bit_split  <= BIT_SPLIT_RST;
         cfg_ff.bit_min    <= BIT_MIN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_LEADER_MAX: cfg_ff.leader_max <= csr_wdata;
            REG_LEADER_MIN: cfg_ff.leader_min <= csr_wdata;
            REG_BIT_SPLIT:  cfg_ff.bit_split  <= csr_wdata;
            REG_BIT_MIN:    cfg_ff.bit_min    <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_interval_ff <= req_tdata;
      end
   end

   irpd_step u_step (
      .cfg           (cfg_ff),
      .state         (state_ff),
      .edge_interval (in_interval_ff),
      .state_next    (state_in),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step_fire) begin
            state_ff <= state_in;
         end
         if (advance) begin
            out_valid_ff <= step_fire && result_in.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && result_in.emit) begin
         out_byte_ff  <= result_in.rx_byte;
         out_index_ff <= result_in.byte_index;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_index_ff, out_byte_ff};

`ifndef SYNTHESIS
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !state_ff.receiving) |-> !result_in.emit)
      else $error("result produced from idle state");

   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !state_ff.receiving) |=>
         (state_ff.bit_count == '0) && (state_ff.shift_byte == '0))
      else $error("idle edge did not clear shift state");

   a_emit_on_byte: assert property (@(posedge clock) disable iff (reset)
      (step_fire && result_in.emit) |=>
         rsp_tvalid && (state_ff.bit_count[2:0] == 3'd0) && (state_ff.shift_byte == '0))
      else $error("byte emitted off a byte boundary");
`endif

endmodule
